// ===== hw/rtl/czn_pkg.sv =====
package czn_pkg;

    localparam int CZN_DEPTH  = 64;

    // Word and accumulator widths
    localparam int SAMPLE_W   = 32;
    localparam int COL_W      = 8;
    localparam int STD_W      = 31;
    localparam int SUM_W      = 38;
    localparam int SQSUM_W    = 56;
    localparam int VAR_W      = 48;

    // Shared divider
    localparam int DIV_NUM_W  = 56;
    localparam int DIV_DEN_W  = 32;

    // Square root unit
    localparam int SQRT_RAD_W  = 64;
    localparam int SQRT_ROOT_W = 32;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_ZERO = 2'd2,
        ST_OVF  = 2'd3
    } t_status;

endpackage

// ===== hw/rtl/czn_if.sv =====
interface czn_in_if;
    import czn_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic        [COL_W-1:0]    column_id;
    logic                       last;

    modport source (output valid, sample, column_id, last, input ready);
    modport sink   (input valid, sample, column_id, last, output ready);
endinterface

interface czn_out_if;
    import czn_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] normalized;
    logic signed [SAMPLE_W-1:0] mean;
    logic        [STD_W-1:0]    std_dev;
    logic        [COL_W-1:0]    column_tag;
    logic        [1:0]          status;
    logic                       final_res;

    modport source (output valid, normalized, mean, std_dev, column_tag, status, final_res,
                    input ready);
    modport sink   (input valid, normalized, mean, std_dev, column_tag, status, final_res,
                    output ready);
endinterface

// ===== hw/rtl/czn_div.sv =====
module czn_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [czn_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [czn_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_done,
    output logic [czn_pkg::DIV_NUM_W-1:0]  o_quot
);
    import czn_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_NUM_W-1:0] r_quot;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;

    logic [DIV_DEN_W:0]   w_trial;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_ge;

    // restoring division, one quotient bit a cycle
    always_comb begin
        w_trial = {r_rem, r_num[DIV_NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
                r_num  <= {r_num[DIV_NUM_W-2:0], 1'b0};
                r_quot <= {r_quot[DIV_NUM_W-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/czn_sqrt.sv =====
module czn_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [czn_pkg::SQRT_RAD_W-1:0]  i_rad,
    output logic                            o_done,
    output logic [czn_pkg::SQRT_ROOT_W:0]   o_root
);
    import czn_pkg::*;

    localparam int CNT_W = $clog2(SQRT_ROOT_W);
    localparam int REM_W = SQRT_ROOT_W + 4;

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [SQRT_RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]       r_rem;
    logic [SQRT_ROOT_W-1:0] r_root;

    logic [REM_W-1:0]       w_rem_sh;
    logic [REM_W-1:0]       w_trial;
    logic                   w_ge;

    // digit-by-digit root, two radicand bits a cycle
    always_comb begin
        w_rem_sh = {r_rem[REM_W-3:0], r_rad[SQRT_RAD_W-1 -: 2]};
        w_trial  = {2'b00, r_root, 2'b01};
        w_ge     = (w_rem_sh >= w_trial);
        // round to nearest: bump when remainder exceeds floor root
        o_root   = (r_rem > REM_W'(r_root)) ? ({1'b0, r_root} + 1'b1) : {1'b0, r_root};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
                r_root <= {r_root[SQRT_ROOT_W-2:0], w_ge};
                r_rad  <= {r_rad[SQRT_RAD_W-3:0], 2'b00};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;

endmodule

// ===== hw/rtl/column_zscore_normalizer_top.sv =====
// Column z-score normaliser.
// Input channel i_in: one word per sample (Q16.16 sample, column id, last flag).
// Samples load at one word a cycle into an on-chip store of DEPTH entries;
// words beyond DEPTH are dropped and the column is flagged as overflowed.
// The word with last set closes the column. The block then stops taking input
// and works through: mean (one serial divide), sum of squared deviations (read,
// absolute deviation, square and accumulate per stored sample, one 32x32
// multiplier), variance (serial divide) and standard deviation (square root),
// the last two skipped for fewer than two samples. Each result needs one store
// read, and a divide unless std_dev is zero; the shared divider sets the rate.
// Output channel o_out: one word per stored sample in load order, with mean,
// std_dev, column tag and status; final_res marks the column's last word.
// A result sits in an output register; the next one is computed while it
// waits, so a stalled receiver only holds the sequencer at hand-over.
// After the final word is handed over the block is ready for the next column.
// Reset (synchronous, active low) empties the store and drops any pending result.
module column_zscore_normalizer_top #(
    parameter int DEPTH = czn_pkg::CZN_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    czn_in_if.sink    i_in,
    czn_out_if.source o_out
);
    import czn_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_LOAD,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_SQ_RD,
        S_SQ_AD,
        S_SQ_MUL,
        S_SQ_ACC,
        S_VAR_GO,
        S_VAR_WAIT,
        S_SQRT_WAIT,
        S_EM_RD,
        S_EM_AD,
        S_EM_DIV,
        S_EM_WAIT,
        S_EM_PUT
    } t_state;

    t_state r_state;

    // sample store
    logic signed [SAMPLE_W-1:0] r_store [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd;

    // column accumulation
    logic [CNT_W-1:0]         r_count;
    logic [IDX_W-1:0]         r_idx;
    logic signed [SUM_W-1:0]  r_sum;
    logic [SQSUM_W-1:0]       r_sqsum;
    logic [COL_W-1:0]         r_held;
    logic                     r_ovf;

    // per-column results
    logic signed [SAMPLE_W-1:0] r_mean;
    logic [STD_W-1:0]           r_std;
    t_status                    r_base;

    // per-sample working registers
    logic [SAMPLE_W-1:0]        r_ad;
    logic                       r_neg;
    logic [2*SAMPLE_W-1:0]      r_prod;
    logic signed [SAMPLE_W-1:0] r_z;
    t_status                    r_z_st;

    // output register
    logic                       r_ov;
    logic signed [SAMPLE_W-1:0] r_o_norm;
    logic signed [SAMPLE_W-1:0] r_o_mean;
    logic [STD_W-1:0]           r_o_std;
    logic [COL_W-1:0]           r_o_tag;
    t_status                    r_o_st;
    logic                       r_o_final;

    // shared units
    logic                   w_div_start;
    logic [DIV_NUM_W-1:0]   w_div_num;
    logic [DIV_DEN_W-1:0]   w_div_den;
    logic                   w_div_done;
    logic [DIV_NUM_W-1:0]   w_div_quot;
    logic                   w_sqrt_start;
    logic [SQRT_RAD_W-1:0]  w_sqrt_rad;
    logic                   w_sqrt_done;
    logic [SQRT_ROOT_W:0]   w_sqrt_root;

    logic                   w_in_acc;
    logic [SUM_W-1:0]       w_abs_sum;
    logic [CNT_W-1:0]       w_nm1;
    logic signed [SAMPLE_W:0] w_d;
    logic [SAMPLE_W:0]      w_ad;
    logic                   w_last_idx;
    logic                   w_skip_div;
    logic [VAR_W-1:0]       w_var;
    logic                   w_std_sat;
    logic [STD_W-1:0]       w_std;
    logic                   w_ovf_now;
    logic [2*SAMPLE_W-1:0]  w_prod_rnd;
    logic                   w_out_free;

    czn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    czn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_rad   (w_sqrt_rad),
        .o_done  (w_sqrt_done),
        .o_root  (w_sqrt_root)
    );

    always_comb begin
        w_in_acc   = i_in.valid && (r_state == S_LOAD);
        w_abs_sum  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        w_nm1      = r_count - 1'b1;
        w_d        = {r_rd[SAMPLE_W-1], r_rd} - {r_mean[SAMPLE_W-1], r_mean};
        w_ad       = w_d[SAMPLE_W] ? (SAMPLE_W + 1)'(-w_d) : (SAMPLE_W + 1)'(w_d);
        w_last_idx = (CNT_W'(r_idx) == w_nm1);
        w_skip_div = (r_base == ST_FEW) || (r_std == '0);
        w_prod_rnd = r_prod + (2*SAMPLE_W)'(32768);
        w_out_free = !r_ov || o_out.ready;

        // variance clamps to 48 bits so that the Q16.16 shift cannot wrap
        w_var = (w_div_quot[DIV_NUM_W-1:VAR_W] != '0) ? '1 : w_div_quot[VAR_W-1:0];
        w_sqrt_rad = {w_var, 16'h0000};

        w_std_sat = (w_sqrt_root[SQRT_ROOT_W:STD_W] != '0);
        w_std     = w_std_sat ? '1 : w_sqrt_root[STD_W-1:0];
        w_ovf_now = r_ovf || w_std_sat;

        w_div_start  = 1'b0;
        w_div_num    = '0;
        w_div_den    = '0;
        w_sqrt_start = 1'b0;
        unique case (r_state)
            S_MEAN_GO: begin
                w_div_start = 1'b1;
                w_div_num   = DIV_NUM_W'(w_abs_sum) + DIV_NUM_W'(r_count >> 1);
                w_div_den   = DIV_DEN_W'(r_count);
            end
            S_VAR_GO: begin
                w_div_start = 1'b1;
                w_div_num   = DIV_NUM_W'(r_sqsum) + DIV_NUM_W'(w_nm1 >> 1);
                w_div_den   = DIV_DEN_W'(w_nm1);
            end
            S_VAR_WAIT: begin
                w_sqrt_start = w_div_done;
            end
            S_EM_DIV: begin
                w_div_start = !w_skip_div;
                w_div_num   = DIV_NUM_W'({r_ad, 16'h0000}) + DIV_NUM_W'(r_std >> 1);
                w_div_den   = DIV_DEN_W'(r_std);
            end
            default: begin
            end
        endcase
    end

    // store: written while loading, read one entry a cycle with registered data
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (r_count < CNT_W'(DEPTH))) begin
            r_store[r_count[IDX_W-1:0]] <= i_in.sample;
        end
        r_rd <= r_store[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_idx   <= '0;
            r_sum   <= '0;
            r_sqsum <= '0;
            r_held  <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            // output register: loaded at hand-over, emptied when taken
            if ((r_state == S_EM_PUT) && w_out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (r_count < CNT_W'(DEPTH)) begin
                            if (r_count == '0) begin
                                r_held <= i_in.column_id;
                            end
                            r_count <= r_count + 1'b1;
                            r_sum   <= r_sum + SUM_W'(i_in.sample);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in.last) begin
                            r_state <= S_MEAN_GO;
                        end
                    end
                end
                S_MEAN_GO: begin
                    r_state <= S_MEAN_WAIT;
                end
                S_MEAN_WAIT: begin
                    if (w_div_done) begin
                        // rounding ties away from zero: divide magnitude, reapply sign
                        r_mean  <= r_sum[SUM_W-1] ? -w_div_quot[SAMPLE_W-1:0]
                                                  : w_div_quot[SAMPLE_W-1:0];
                        r_idx   <= '0;
                        r_sqsum <= '0;
                        r_state <= S_SQ_RD;
                    end
                end
                S_SQ_RD: begin
                    r_state <= S_SQ_AD;
                end
                S_SQ_AD: begin
                    r_ad    <= w_ad[SAMPLE_W-1:0];
                    r_state <= S_SQ_MUL;
                end
                S_SQ_MUL: begin
                    r_prod  <= r_ad * r_ad;
                    r_state <= S_SQ_ACC;
                end
                S_SQ_ACC: begin
                    r_sqsum <= r_sqsum + SQSUM_W'(w_prod_rnd[2*SAMPLE_W-1:16]);
                    if (w_last_idx) begin
                        r_idx <= '0;
                        if (r_count < CNT_W'(2)) begin
                            r_std   <= '0;
                            r_base  <= ST_FEW;
                            r_state <= S_EM_RD;
                        end else begin
                            r_state <= S_VAR_GO;
                        end
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SQ_RD;
                    end
                end
                S_VAR_GO: begin
                    r_state <= S_VAR_WAIT;
                end
                S_VAR_WAIT: begin
                    if (w_div_done) begin
                        r_state <= S_SQRT_WAIT;
                    end
                end
                S_SQRT_WAIT: begin
                    if (w_sqrt_done) begin
                        r_std <= w_std;
                        r_ovf <= w_ovf_now;
                        if (w_ovf_now) begin
                            r_base <= ST_OVF;
                        end else if (w_std == '0) begin
                            r_base <= ST_ZERO;
                        end else begin
                            r_base <= ST_OK;
                        end
                        r_state <= S_EM_RD;
                    end
                end
                S_EM_RD: begin
                    r_state <= S_EM_AD;
                end
                S_EM_AD: begin
                    r_ad    <= w_ad[SAMPLE_W-1:0];
                    r_neg   <= w_d[SAMPLE_W];
                    r_state <= S_EM_DIV;
                end
                S_EM_DIV: begin
                    if (w_skip_div) begin
                        r_z     <= '0;
                        r_z_st  <= r_base;
                        r_state <= S_EM_PUT;
                    end else begin
                        r_state <= S_EM_WAIT;
                    end
                end
                S_EM_WAIT: begin
                    if (w_div_done) begin
                        if (r_neg) begin
                            if (w_div_quot > DIV_NUM_W'(33'h0_8000_0000)) begin
                                r_z    <= {1'b1, {(SAMPLE_W-1){1'b0}}};
                                r_z_st <= ST_OVF;
                            end else begin
                                r_z    <= -w_div_quot[SAMPLE_W-1:0];
                                r_z_st <= r_base;
                            end
                        end else begin
                            if (w_div_quot > DIV_NUM_W'(32'h7FFF_FFFF)) begin
                                r_z    <= {1'b0, {(SAMPLE_W-1){1'b1}}};
                                r_z_st <= ST_OVF;
                            end else begin
                                r_z    <= w_div_quot[SAMPLE_W-1:0];
                                r_z_st <= r_base;
                            end
                        end
                        r_state <= S_EM_PUT;
                    end
                end
                S_EM_PUT: begin
                    if (w_out_free) begin
                        r_o_norm  <= r_z;
                        r_o_mean  <= r_mean;
                        r_o_std   <= r_std;
                        r_o_tag   <= r_held;
                        r_o_st    <= r_z_st;
                        r_o_final <= w_last_idx;
                        if (w_last_idx) begin
                            // column done: clear for the next one
                            r_count <= '0;
                            r_idx   <= '0;
                            r_sum   <= '0;
                            r_sqsum <= '0;
                            r_held  <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_EM_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_LOAD);
    assign o_out.valid      = r_ov;
    assign o_out.normalized = r_o_norm;
    assign o_out.mean       = r_o_mean;
    assign o_out.std_dev    = r_o_std;
    assign o_out.column_tag = r_o_tag;
    assign o_out.status     = r_o_st;
    assign o_out.final_res  = r_o_final;

endmodule

// ===== dv/tb_czn_if.sv =====
`timescale 1ns / 100ps

// Testbench-side copies are not needed: the RTL interfaces are reused.
// This file holds the word types shared by the stimulus and checker.
package tb_czn_pkg;
    import czn_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic        [COL_W-1:0]    column_id;
        logic                       last;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] normalized;
        logic signed [SAMPLE_W-1:0] mean;
        logic        [STD_W-1:0]    std_dev;
        logic        [COL_W-1:0]    column_tag;
        t_status                    status;
        logic                       final_res;
    } t_out_word;
endpackage

// ===== dv/tb_column_zscore_normalizer_top.sv =====
`timescale 1ns / 100ps

module tb_column_zscore_normalizer_top;
    import czn_pkg::*;
    import tb_czn_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    czn_in_if  in_ch ();
    czn_out_if out_ch ();

    column_zscore_normalizer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // column predictor state
    logic signed [SAMPLE_W-1:0] col_store [CZN_DEPTH];
    int unsigned                col_count;
    logic signed [63:0]         col_sum;
    logic [COL_W-1:0]           col_tag;
    bit                         col_ovf;

    t_out_word zscore_queue [$];
    int        fail_count = 0;
    int        idle_cycles = 0;
    int        out_wait = 0;
    bit        stim_done;

    function automatic logic [63:0] isqrt_round(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (v > r) r = r + 1;
        return r;
    endfunction

    function automatic logic [63:0] mag64(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // take one word; on last push the column's z-scores
    task automatic predict_column(t_in_word w);
        logic signed [63:0] mean_v;
        logic signed [63:0] d;
        logic [63:0]        q;
        logic [63:0]        sqs;
        logic [63:0]        ad;
        logic [63:0]        var_v;
        logic [63:0]        sd;
        logic [63:0]        z;
        t_status            base;
        t_out_word          r;
        if (col_count < CZN_DEPTH) begin
            if (col_count == 0) col_tag = w.column_id;
            col_store[col_count] = w.sample;
            col_count++;
            col_sum += w.sample;
        end else begin
            col_ovf = 1'b1;
        end
        if (!w.last) return;
        q = (mag64(col_sum) + col_count / 2) / col_count;
        mean_v = col_sum < 0 ? -$signed(q) : $signed(q);
        sqs = '0;
        for (int i = 0; i < col_count; i++) begin
            ad = mag64(col_store[i] - mean_v);
            sqs += (ad * ad + 64'd32768) >> 16;
        end
        sd = '0;
        if (col_count < 2) begin
            base = ST_FEW;
        end else begin
            var_v = (sqs + (col_count - 1) / 2) / (col_count - 1);
            if (var_v > (64'hFFFF_FFFF_FFFF_FFFF >> 16)) var_v = 64'hFFFF_FFFF_FFFF_FFFF >> 16;
            sd = isqrt_round(var_v << 16);
            if (sd > 64'h7FFF_FFFF) begin
                sd = 64'h7FFF_FFFF;
                col_ovf = 1'b1;
            end
            base = col_ovf ? ST_OVF : (sd == 0 ? ST_ZERO : ST_OK);
        end
        for (int i = 0; i < col_count; i++) begin
            d = col_store[i] - mean_v;
            r.status = base;
            r.normalized = '0;
            if (base != ST_FEW && sd != 0) begin
                z = ((mag64(d) << 16) + sd / 2) / sd;
                if (d < 0) begin
                    if (z > 64'h8000_0000) begin
                        z = 64'h8000_0000;
                        r.status = ST_OVF;
                    end
                    r.normalized = -z[31:0];
                end else begin
                    if (z > 64'h7FFF_FFFF) begin
                        z = 64'h7FFF_FFFF;
                        r.status = ST_OVF;
                    end
                    r.normalized = z[31:0];
                end
            end
            r.mean = mean_v[31:0];
            r.std_dev = sd[30:0];
            r.column_tag = col_tag;
            r.final_res = (i + 1 == col_count);
            zscore_queue.push_back(r);
        end
        col_count = 0;
        col_sum = '0;
        col_tag = '0;
        col_ovf = 1'b0;
    endtask

    // directed table: {sample, column_id, last}, typed expectation where obvious
    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word exp_w;
    } t_row;

    t_row      table_rows [$];
    t_out_word typed_queue [$];

    task automatic add_row(logic [31:0] s, logic [7:0] c, bit l);
        t_row r;
        r.w = '{s, c, l};
        r.typed = 1'b0;
        r.exp_w = '0;
        table_rows.push_back(r);
    endtask

    task automatic add_typed(logic [31:0] s, logic [7:0] c, t_out_word e);
        t_row r;
        r.w = '{s, c, 1'b1};
        r.typed = 1'b1;
        r.exp_w = e;
        table_rows.push_back(r);
    endtask

    // valid stays high into the next word when no gap is drawn
    task automatic send_word(t_in_word w);
        int gap;
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample <= w.sample;
        in_ch.column_id <= w.column_id;
        in_ch.last <= w.last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_column(w);
    endtask

    task automatic send_column(int len, int mode);
        t_in_word w;
        logic [7:0] c;
        logic [31:0] base;
        c = 8'($urandom);
        base = $urandom;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: w.sample = $urandom;
                1: w.sample = $signed(base) + $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
                2: w.sample = base;
                default: w.sample = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            endcase
            w.column_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : c;
            w.last = (i == len - 1);
            send_word(w);
        end
    endtask

    // output side: per-word wait, compare against typed row or predictor
    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.normalized, out_ch.mean, out_ch.std_dev,
                        out_ch.column_tag, t_status'(out_ch.status), out_ch.final_res};
                if (zscore_queue.size() == 0) begin
                    $error("unexpected result word");
                    fail_count++;
                end else begin
                    want = zscore_queue.pop_front();
                    // a matching typed table row replaces the predictor's expectation
                    if (typed_queue.size() != 0 && want.final_res && want.column_tag ==
                        typed_queue[0].column_tag && want.mean == typed_queue[0].mean)
                        want = typed_queue.pop_front();
                    if (got.normalized !== want.normalized) begin
                        $error("normalized exp %0d got %0d", want.normalized, got.normalized);
                        fail_count++;
                    end
                    if (got.mean !== want.mean) begin
                        $error("mean exp %0d got %0d", want.mean, got.mean);
                        fail_count++;
                    end
                    if (got.std_dev !== want.std_dev) begin
                        $error("std_dev exp %0d got %0d", want.std_dev, got.std_dev);
                        fail_count++;
                    end
                    if (got.column_tag !== want.column_tag) begin
                        $error("column_tag exp %0d got %0d", want.column_tag, got.column_tag);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.final_res !== want.final_res) begin
                        $error("final_res exp %0d got %0d", want.final_res, got.final_res);
                        fail_count++;
                    end
                end
                // wait drawn per word, none once stimulus is done
                out_wait = stim_done ? 0 : int'($urandom_range(0, 18));
            end else if (out_wait > 0) begin
                out_wait--;
            end
            out_ch.ready <= (out_wait == 0);
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("tb_column_zscore_normalizer_top NOT OK");
            $finish;
        end
    end

    initial begin
        t_out_word e;
        int n_items;
        int len;
        stim_done = 1'b0;
        col_count = 0;
        col_sum = '0;
        col_tag = '0;
        col_ovf = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.column_id = '0;
        in_ch.last = 1'b0;

        // single sample, most positive then most negative: status few, mean is the sample
        e = '{32'sd0, 32'sh7FFF_FFFF, 31'd0, 8'hFF, ST_FEW, 1'b1};
        add_typed(32'h7FFF_FFFF, 8'hFF, e);
        e = '{32'sd0, 32'sh8000_0000, 31'd0, 8'h00, ST_FEW, 1'b1};
        add_typed(32'h8000_0000, 8'h00, e);
        // two equal samples: zero deviation
        add_row(32'h0001_0000, 8'h5A, 1'b0);
        e = '{32'sd0, 32'sh0001_0000, 31'd0, 8'h5A, ST_ZERO, 1'b1};
        add_typed(32'h0001_0000, 8'hA5, e);
        // extremes together: deviation saturates
        add_row(32'h7FFF_FFFF, 8'h11, 1'b0);
        add_row(32'h8000_0000, 8'h22, 1'b0);
        add_row(32'h7FFF_FFFF, 8'h33, 1'b1);
        // ordinary column, column id change ignored
        add_row(32'h0002_0000, 8'h44, 1'b0);
        add_row(32'hFFFE_0000, 8'h45, 1'b0);
        add_row(32'h0000_8000, 8'h46, 1'b1);
        // tiny deviation: variance rounds to zero, status zero
        add_row(32'h0000_0000, 8'h01, 1'b0);
        add_row(32'h0000_0001, 8'h01, 1'b0);
        add_row(32'h0000_0000, 8'h01, 1'b1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[k]) begin
            if (table_rows[k].typed) typed_queue.push_back(table_rows[k].exp_w);
            send_word(table_rows[k].w);
        end
        // overfill the store: dropped words, last one dropped too
        for (int i = 0; i < CZN_DEPTH + 2; i++)
            send_word('{32'($urandom), 8'h77, i == CZN_DEPTH + 1});
        in_ch.valid <= 1'b0;

        // hold off until the block has drained
        while (zscore_queue.size() != 0) @(posedge i_clk);

        n_items = 0;
        while (n_items < 380) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 8);
            send_column(len, $urandom_range(0, 5) < 3 ? 1 : $urandom_range(0, 3));
            n_items += len;
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;

        while (zscore_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_column_zscore_normalizer_top OK");
        else
            $display("tb_column_zscore_normalizer_top NOT OK");
        $finish;
    end
endmodule
